FILE: rtl/core/ttdh_pkg.sv
// Shared types and constants for the threshold trigger with delay and holdoff.
package ttdh_pkg;

	// Width of the sample and threshold values
	localparam int unsigned SAMPLE_W = 32;
	// Width of the delay and min_gap registers
	localparam int unsigned GAP_W = 16;
	// Width of the configuration write data
	localparam int unsigned CFG_DATA_W = 32;
	// Width of the configuration register index
	localparam int unsigned CFG_IDX_W = 2;

	// Detection modes
	typedef enum logic [1:0] {
		MODE_ABOVE   = 2'd0,
		MODE_BELOW   = 2'd1,
		MODE_RISING  = 2'd2,
		MODE_FALLING = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE      = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_DELAY     = 2'd2,
		CFG_MIN_GAP   = 2'd3
	} cfg_idx_t;

endpackage

FILE: rtl/core/threshold_trigger_delay_holdoff.sv
// Threshold trigger with delay and holdoff: one fire flag per signed sample.
//
// Each transfer on the sample channel gives exactly one transfer on the fire
// channel, in order. A sample is taken into an input register, then the
// detection test, the elapsed counter step and the fire compare run
// combinationally into the output register, so one sample per clock is
// sustained when fire is not stalled. A detection (above or below the
// threshold, or a rising or falling crossing) starts the elapsed counter;
// fire is 1 on the sample where the count equals delay, and the trigger
// re-arms once the count passes delay + min_gap. A detection on the first
// sample after reset is dropped. delay and min_gap are used at COUNT_WIDTH
// bits. Configuration writes are always accepted (cfg_ready is tied high)
// and take effect on the next processed sample.
module threshold_trigger_delay_holdoff
	import ttdh_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample,
	// fire channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        fire,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam int unsigned EL_W = COUNT_WIDTH + 1;

	// Configuration registers
	mode_t                       mode_q;
	logic signed [SAMPLE_W-1:0]  threshold_q;
	logic [GAP_W-1:0]            delay_q;
	logic [GAP_W-1:0]            min_gap_q;

	// Trigger state
	logic             primed_q;
	logic             counting_q;
	logic             was_beyond_q;
	logic [EL_W-1:0]  elapsed_q;

	// Input stage and output register
	logic                        valid_s1;
	logic signed [SAMPLE_W-1:0]  sample_s1;
	logic                        out_valid_q;
	logic                        fire_q;

	// Handshake control
	logic out_load;
	logic in_load;

	// Next-state values
	logic [COUNT_WIDTH-1:0]  d_c;
	logic [COUNT_WIDTH-1:0]  g_c;
	logic [EL_W-1:0]         limit;
	logic [EL_W-1:0]         el_inc;
	logic                    above;
	logic                    below;
	logic                    detect;
	logic                    was_beyond_d;
	logic                    count_now;
	logic                    counting_d;
	logic [EL_W-1:0]         elapsed_d;
	logic                    fire_d;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ABOVE;
			threshold_q <= '0;
			delay_q     <= '0;
			min_gap_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:      mode_q      <= mode_t'(cfg_data[1:0]);
				CFG_THRESHOLD: threshold_q <= $signed(cfg_data[SAMPLE_W-1:0]);
				CFG_DELAY:     delay_q     <= cfg_data[GAP_W-1:0];
				CFG_MIN_GAP:   min_gap_q   <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: output register frees when empty or taken
	assign out_load  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_load   = !valid_s1 || out_load;
	assign in_stall  = !in_load;
	assign out_valid = out_valid_q;
	assign fire      = fire_q;

	// Detection test
	always_comb begin
		above        = sample_s1 > threshold_q;
		below        = sample_s1 < threshold_q;
		detect       = 1'b0;
		was_beyond_d = was_beyond_q;
		unique case (mode_q)
			MODE_ABOVE:  detect = above;
			MODE_BELOW:  detect = below;
			MODE_RISING: begin
				detect       = above && !was_beyond_q;
				was_beyond_d = above;
			end
			MODE_FALLING: begin
				detect       = below && !was_beyond_q;
				was_beyond_d = below;
			end
			default: ;
		endcase
		// was_beyond only moves while the counter is idle
		if (counting_q)
			was_beyond_d = was_beyond_q;
	end

	// Counter step and fire compare
	always_comb begin
		d_c        = COUNT_WIDTH'(delay_q);
		g_c        = COUNT_WIDTH'(min_gap_q);
		limit      = EL_W'(d_c) + EL_W'(g_c);
		el_inc     = elapsed_q + EL_W'(1);
		count_now  = (counting_q || detect) && primed_q;
		counting_d = count_now;
		elapsed_d  = elapsed_q;
		fire_d     = 1'b0;
		if (count_now) begin
			fire_d = (elapsed_q == EL_W'(d_c));
			if (el_inc > limit) begin
				counting_d = 1'b0;
				elapsed_d  = '0;
			end else begin
				elapsed_d = el_inc;
			end
		end
	end

	// Trigger state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			counting_q   <= 1'b0;
			was_beyond_q <= 1'b0;
			elapsed_q    <= '0;
		end else if (out_load) begin
			primed_q     <= 1'b1;
			counting_q   <= counting_d;
			was_beyond_q <= was_beyond_d;
			elapsed_q    <= elapsed_d;
		end
	end

	// Input stage valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_load)
				valid_s1 <= in_valid;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_load && in_valid)
			sample_s1 <= sample;
		if (out_load)
			fire_q <= fire_d;
	end

endmodule

FILE: test/threshold_trigger_delay_holdoff_check.sv
// Scoreboard for the threshold trigger: predicts every fire flag and checks it in order.
module threshold_trigger_delay_holdoff_check
	import ttdh_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       fire,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         errors,
	output int                         outstanding,
	output int                         pulses
);

	// trigger settings as last written
	mode_t                      trig_mode;
	logic signed [SAMPLE_W-1:0] trig_level;
	logic [GAP_W-1:0]           trig_delay;
	logic [GAP_W-1:0]           trig_gap;

	// trigger state; the counter is one bit wider than delay and min_gap
	logic           primed;
	logic           counting;
	logic           was_beyond;
	logic [GAP_W:0] elapsed;

	// fire flags still owed by the block, oldest first
	logic fire_due[$];
	int   results_seen;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at result %0d: %s", results_seen, what);
		errors++;
	endtask

	// one sample through the trigger; returns the fire flag it produces
	function automatic logic step_trigger(input logic signed [SAMPLE_W-1:0] s);
		logic           above;
		logic           below;
		logic           hit;
		logic [GAP_W:0] rearm_at;
		above    = s > trig_level;
		below    = s < trig_level;
		hit      = 1'b0;
		rearm_at = {1'b0, trig_delay} + {1'b0, trig_gap};

		// detection runs only while the counter is idle
		if (!counting) begin
			case (trig_mode)
				MODE_ABOVE: begin
					if (above) counting = 1'b1;
				end
				MODE_BELOW: begin
					if (below) counting = 1'b1;
				end
				MODE_RISING: begin
					if (above && !was_beyond) counting = 1'b1;
					was_beyond = above;
				end
				MODE_FALLING: begin
					if (below && !was_beyond) counting = 1'b1;
					was_beyond = below;
				end
				default: ;
			endcase
		end

		// a detection on the very first sample is dropped
		if (!primed) counting = 1'b0;
		primed = 1'b1;

		// count, fire at the delay, re-arm once past delay + min_gap
		if (counting) begin
			hit     = (elapsed == {1'b0, trig_delay});
			elapsed = elapsed + 1'b1;
			if (elapsed > rearm_at) begin
				counting = 1'b0;
				elapsed  = '0;
			end
		end
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			trig_mode    = MODE_ABOVE;
			trig_level   = '0;
			trig_delay   = '0;
			trig_gap     = '0;
			primed       = 1'b0;
			counting     = 1'b0;
			was_beyond   = 1'b0;
			elapsed      = '0;
			fire_due.delete();
			errors       = 0;
			pulses       = 0;
			results_seen = 0;
			outstanding <= 0;
		end else begin
			// fire transfer: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				if (fire_due.size() == 0) begin
					report_mismatch($sformatf("fire=%0b with no sample pending", fire));
				end else begin
					want = fire_due.pop_front();
					if (fire !== want)
						report_mismatch($sformatf("fire=%0b, predicted %0b", fire, want));
				end
				if (fire === 1'b1) pulses++;
				results_seen++;
			end

			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MODE:      trig_mode  = mode_t'(cfg_data[1:0]);
					CFG_THRESHOLD: trig_level = cfg_data[SAMPLE_W-1:0];
					CFG_DELAY:     trig_delay = cfg_data[GAP_W-1:0];
					CFG_MIN_GAP:   trig_gap   = cfg_data[GAP_W-1:0];
					default: ;
				endcase
			end

			// sample transfer: predict its fire flag
			if (in_valid && !in_stall) fire_due.push_back(step_trigger(sample));

			outstanding <= fire_due.size();
		end
	end

endmodule

FILE: test/threshold_trigger_delay_holdoff_test.sv
// Top of the threshold trigger testbench: clock, reset, stimulus and verdict.
module threshold_trigger_delay_holdoff_test;
	import ttdh_pkg::*;

	// stalls are random at up to 73%, so a long quiet stretch means a hang
	localparam int QUIET_LIMIT  = 2000;
	localparam int SEGMENTS     = 12;
	localparam int SEGMENT_LEN  = 165;
	localparam int DRAIN_CYCLES = 4;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       fire;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = CFG_MODE;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;

	int errors;
	int outstanding;
	int pulses;
	int send_idle     = 0;
	int recv_idle     = 0;
	int samples_sent  = 0;
	int settings_used = 1;
	int quiet         = 0;

	threshold_trigger_delay_holdoff dut (.*);

	threshold_trigger_delay_holdoff_check checker_i (.*);

	always #5 clk = ~clk;

	// fire side stalls at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("threshold_trigger_delay_holdoff test failed");
			$finish;
		end
	end

	// one sample transfer, after an optional random gap
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		do @(posedge clk); while (in_stall);
		samples_sent++;
	endtask

	// stop sending and wait until every fire flag is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// new settings, written only with the block drained; junk in the unused upper bits
	task automatic program_trigger(input mode_t m, input logic signed [SAMPLE_W-1:0] level,
	                               input logic [GAP_W-1:0] dly, input logic [GAP_W-1:0] gap);
		wait_drained();
		write_reg(CFG_MODE, ($urandom & ~32'h3) | m);
		write_reg(CFG_THRESHOLD, level);
		write_reg(CFG_DELAY, ($urandom & 32'hFFFF_0000) | dly);
		write_reg(CFG_MIN_GAP, ($urandom & 32'hFFFF_0000) | gap);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// mostly close to the threshold so that crossings are frequent
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
		input logic signed [SAMPLE_W-1:0] level);
		logic signed [SAMPLE_W-1:0] value;
		case ($urandom_range(0, 9))
			0: value = $urandom;
			1: value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: value = level + $urandom_range(0, 8) - 4;
		endcase
		return value;
	endfunction

	initial begin
		logic signed [SAMPLE_W-1:0] level;
		logic [GAP_W-1:0]           dly;
		logic [GAP_W-1:0]           gap;
		int                         len;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: above zero, no delay, no holdoff; first detection is dropped
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sd5);
		send_sample(32'sd0);
		send_sample(-32'sd1);
		send_sample(32'sh8000_0000);
		send_sample(32'sd1);

		// below the top level, fire one sample after detection, then hold off
		program_trigger(MODE_BELOW, 32'sh7FFF_FFFF, 16'd1, 16'd2);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'sd0);
		send_sample(32'sd0);
		send_sample(32'sd0);

		// rising crossing at -5: staying above does not fire again
		program_trigger(MODE_RISING, -32'sd5, 16'd0, 16'd0);
		send_sample(-32'sd5);
		send_sample(-32'sd4);
		send_sample(-32'sd3);
		send_sample(-32'sd6);
		send_sample(-32'sd4);

		// falling crossing; delay and holdoff shortened while counting stops the count
		program_trigger(MODE_FALLING, 32'sd100, 16'd3, 16'd1);
		send_sample(32'sd200);
		send_sample(32'sd99);
		program_trigger(MODE_FALLING, 32'sd100, 16'd0, 16'd0);
		send_sample(32'sd50);
		send_sample(32'sd40);
		send_sample(32'sd150);
		send_sample(32'sd10);

		// random segments: every mode under each idling pattern
		for (int k = 0; k < SEGMENTS; k++) begin
			send_idle = (k < 4) ? 17 : (k < 8) ? 73 : 0;
			recv_idle = (k < 4) ? 73 : (k < 8) ? 17 : 0;
			dly = $urandom_range(0, 6);
			gap = $urandom_range(0, 8);
			len = SEGMENT_LEN;
			if (k == 5) begin
				// longest delay and holdoff: a detection keeps counting to the end
				dly = '1;
				gap = '1;
				len = 40;
			end else if (k == 10) begin
				dly = '0;
				gap = '0;
			end
			if (k == 1) begin
				level = 32'sh7FFF_FFFF;
			end else if (k == 4) begin
				level = 32'sh8000_0000;
			end else if (k % 3 == 0) begin
				level = $urandom;
			end else begin
				level = $urandom_range(0, 2000);
				level = level - 1000;
			end
			program_trigger(mode_t'(k[1:0]), level, dly, gap);
			repeat (len) send_sample(pick_sample(level));
		end

		wait_drained();
		$display("covered %0d samples under %0d trigger settings, all four modes,",
		         samples_sent, settings_used);
		$display("with and without idling; %0d fire pulses seen, %0d mismatches",
		         pulses, errors);
		if (errors == 0)
			$display("threshold_trigger_delay_holdoff test passed");
		else
			$display("threshold_trigger_delay_holdoff test failed");
		$finish;
	end

endmodule
